// ----- rtl/rol_pkg.sv -----
`default_nettype none

package rol_pkg;

  localparam int PortW   = 8;
  localparam int CountW  = 4;
  localparam int StatusW = 2;

  typedef logic [PortW-1:0]   port_t;
  typedef logic [CountW-1:0]  entry_count_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    REQ_PLUG   = 1'b0,
    REQ_UNPLUG = 1'b1
  } req_type_t;

  typedef struct packed {
    logic  plug_en;
    logic  shift_en;
    port_t port;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/rol_ifs.sv -----
`default_nettype none

interface rol_req_if;
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [7:0]           port_id;

  modport source (output valid, req_type, port_id, input ready);
  modport sink (input valid, req_type, port_id, output ready);
endinterface

interface rol_res_if;
  logic                 valid;
  logic                 ready;
  logic [7:0]           active_port;
  logic                 active_valid;
  logic [3:0]           entry_count;
  logic [1:0]           status;

  modport source (output valid, active_port, active_valid, entry_count, status, input ready);
  modport sink (input valid, active_port, active_valid, entry_count, status, output ready);
endinterface

`default_nettype wire

// ----- rtl/rol_cell.sv -----
`default_nettype none

module rol_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rol_pkg::cell_ctrl_t ctrl,
  input  wire logic               left_occ,
  input  wire logic               hit_in,
  input  wire rol_pkg::port_t     right_data,
  input  wire logic               right_occ,
  output rol_pkg::port_t          data,
  output logic                    occ,
  output logic                    hit_out
);
  import rol_pkg::*;

  logic match;
  logic load_plug;
  logic load_shift;

  assign match      = occ && (data == ctrl.port);
  assign hit_out    = hit_in || match;
  assign load_plug  = ctrl.plug_en && left_occ && !occ;
  assign load_shift = ctrl.shift_en && hit_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (load_plug) begin
      occ <= 1'b1;
    end else if (load_shift) begin
      occ <= right_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (load_plug) begin
      data <= ctrl.port;
    end else if (load_shift) begin
      data <= right_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/recency_ordered_input_list_core.sv -----
`default_nettype none

// Recency-ordered list of plugged-in ports, oldest entry first.
// The req channel carries one request per beat: req_type selects plug (append
// port_id at the tail) or unplug (remove the oldest matching entry, later
// entries move down one place). The res channel returns one beat per request
// with the tail entry, a valid flag, the entry count and a status code.
// Each list slot is one cell; the match search runs as a hit chain from the
// oldest cell toward the newest, and every cell at or above the hit loads its
// newer neighbor in the same cycle.
// An accepted request updates the cells, count and status; its result beat
// then loads into the output register once free. Throughput: one request per
// cycle while res is taken every cycle, set by one cell-row update per request.
// Reset empties the list, clears the count and drops any pending result.
// When the receiver stalls, the result beat holds in the output register, one
// further request is accepted and parked, and req.ready then drops until the
// output register frees up.
module recency_ordered_input_list_core #(
  parameter int LIST_DEPTH = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  rol_req_if.sink   req,
  rol_res_if.source res
);
  import rol_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);

  cell_ctrl_t            ctrl;
  port_t                 cell_data [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] occ;
  logic [LIST_DEPTH:0]   hit;
  logic [LIST_DEPTH-1:0] left_occ;
  logic [LIST_DEPTH-1:0] tail_sel;
  port_t                 tail_port;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          pend;
  status_t       st;
  status_t       st_next;
  logic          accept;
  logic          move;
  logic          full;
  logic          found;
  logic          is_unplug;

  assign hit[0]      = 1'b0;
  assign left_occ[0] = 1'b1;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    port_t right_data;
    logic  right_occ;

    if (i == LIST_DEPTH - 1) begin : g_last
      assign right_data = '0;
      assign right_occ  = 1'b0;
      assign tail_sel[i] = occ[i];
    end else begin : g_mid
      assign right_data = cell_data[i+1];
      assign right_occ  = occ[i+1];
      assign tail_sel[i] = occ[i] && !occ[i+1];
      assign left_occ[i+1] = occ[i];
    end

    rol_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .left_occ   (left_occ[i]),
      .hit_in     (hit[i]),
      .right_data (right_data),
      .right_occ  (right_occ),
      .data       (cell_data[i]),
      .occ        (occ[i]),
      .hit_out    (hit[i+1])
    );
  end

  always_comb begin
    tail_port = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      tail_port = tail_port | (tail_sel[i] ? cell_data[i] : '0);
    end
  end

  assign full      = occ[LIST_DEPTH-1];
  assign found     = hit[LIST_DEPTH];
  assign is_unplug = (req.req_type == REQ_UNPLUG);
  assign move      = pend && (!res.valid || res.ready);
  assign req.ready = !pend || move;
  assign accept    = req.valid && req.ready;

  assign ctrl.plug_en  = accept && !is_unplug && !full;
  assign ctrl.shift_en = accept && is_unplug && found;
  assign ctrl.port     = req.port_id;

  always_comb begin
    count_next = count;
    if (!is_unplug) begin
      st_next = full ? ST_FULL : ST_OK;
      if (!full) begin
        count_next = count + CW'(1);
      end
    end else if (count == '0) begin
      st_next = ST_EMPTY;
    end else if (!found) begin
      st_next = ST_NOT_FOUND;
    end else begin
      st_next    = ST_OK;
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pend      <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
        st    <= st_next;
      end
      if (accept) begin
        pend <= 1'b1;
      end else if (move) begin
        pend <= 1'b0;
      end
      if (move) begin
        res.valid        <= 1'b1;
        res.active_port  <= tail_port;
        res.active_valid <= (count != '0);
        res.entry_count  <= 4'(count);
        res.status       <= st;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  a_count_matches_cells : assert property (@(posedge clk) disable iff (rst)
    $countones(occ) == int'(count))
    else $error("entry count disagrees with occupied cells");

  a_cells_packed : assert property (@(posedge clk) disable iff (rst)
    (occ & (occ + LIST_DEPTH'(1))) == '0)
    else $error("occupied cells are not packed from the oldest slot");

  a_valid_has_entries : assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.active_valid) |-> ((res.entry_count != '0) || (LIST_DEPTH >= 16)))
    else $error("active port flagged valid with an empty count");

  a_full_rejects_plug : assert property (@(posedge clk) disable iff (rst)
    (accept && !is_unplug && full) |=> (st == ST_FULL && $stable(occ)))
    else $error("plug into a full list changed the cells");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import rol_pkg::*;

  localparam int LIST_DEPTH   = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    port_t        active_port;
    logic         active_valid;
    entry_count_t entry_count;
    status_t      status;
  } list_view_t;

  logic clk;
  logic rst;

  rol_req_if req_ch ();
  rol_res_if res_ch ();

  recency_ordered_input_list_core #(
    .LIST_DEPTH(LIST_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  port_t      model_ports[LIST_DEPTH] = '{default: '0};
  int         model_count = 0;
  list_view_t view_q[$];
  int         errors = 0;
  int         hold_len = 0;
  bit         no_idle = 1'b0;
  int         cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Applies one request to the shadow list and returns what the block should report.
  function automatic list_view_t update_port_list(req_type_t kind, port_t port);
    list_view_t view;
    status_t    st;
    int         hit;
    st  = ST_OK;
    hit = -1;
    if (kind == REQ_PLUG) begin
      if (model_count >= LIST_DEPTH) begin
        st = ST_FULL;
      end else begin
        model_ports[model_count] = port;
        model_count++;
      end
    end else if (model_count == 0) begin
      st = ST_EMPTY;
    end else begin
      for (int k = 0; k < model_count; k++) begin
        if (hit < 0 && model_ports[k] == port) hit = k;
      end
      if (hit < 0) begin
        st = ST_NOT_FOUND;
      end else begin
        for (int k = hit; k < model_count - 1; k++) model_ports[k] = model_ports[k + 1];
        model_count--;
        model_ports[model_count] = '0;
      end
    end
    view.active_valid = (model_count > 0);
    view.active_port  = (model_count > 0) ? model_ports[model_count - 1] : '0;
    view.entry_count  = entry_count_t'(model_count);
    view.status       = st;
    return view;
  endfunction

  task automatic send_request(req_type_t kind, port_t port);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.port_id  <= port;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    view_q.push_back(update_port_list(kind, port));
  endtask

  task automatic pause_until_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (view_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    list_view_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (view_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with no request outstanding", $time);
      end else begin
        want = view_q.pop_front();
        check_field("active_port", want.active_port, res_ch.active_port);
        check_field("active_valid", want.active_valid, res_ch.active_valid);
        check_field("entry_count", want.entry_count, res_ch.entry_count);
        check_field("status", want.status, res_ch.status);
      end
    end
  end

  // The receiver stalls at random, and holds off for a stall set by hold_len when asked.
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        res_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        res_ch.ready <= 1'b1;
      end else if (no_idle || $urandom_range(0, 3) != 0) begin
        res_ch.ready <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          res_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic test_empty_list();
    send_request(REQ_UNPLUG, 8'h00);
    send_request(REQ_UNPLUG, 8'hFF);
  endtask

  task automatic test_fill_to_full();
    port_t fill_ports[8] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h03, 8'h03, 8'h07, 8'h80};
    foreach (fill_ports[i]) send_request(REQ_PLUG, fill_ports[i]);
    send_request(REQ_PLUG, 8'h09);
  endtask

  task automatic test_unplug_order();
    send_request(REQ_UNPLUG, 8'hC8);
    send_request(REQ_UNPLUG, 8'h03);
    send_request(REQ_UNPLUG, 8'h80);
    send_request(REQ_UNPLUG, 8'h00);
    // Cleared slots above the count hold zero and must not match.
    send_request(REQ_UNPLUG, 8'h00);
    send_request(REQ_UNPLUG, 8'h03);
    send_request(REQ_UNPLUG, 8'hFF);
    send_request(REQ_UNPLUG, 8'h55);
    send_request(REQ_UNPLUG, 8'hAA);
    send_request(REQ_UNPLUG, 8'h07);
  endtask

  task automatic test_backpressure();
    no_idle  = 1'b1;
    hold_len = 40;
    for (int n = 0; n < 12; n++) begin
      send_request((n % 3 == 2) ? REQ_UNPLUG : REQ_PLUG, port_t'($urandom_range(0, 7)));
    end
    no_idle = 1'b0;
    pause_until_drained();
  endtask

  task automatic test_random_traffic();
    int        plug_pct;
    int        r;
    req_type_t kind;
    port_t     port;
    for (int ph = 0; ph < 22; ph++) begin
      plug_pct = (ph % 3 == 0) ? 75 : (ph % 3 == 1) ? 50 : 25;
      no_idle  = (ph % 5 == 4);
      if (ph == 11) pause_until_drained();
      for (int n = 0; n < 50; n++) begin
        kind = ($urandom_range(0, 99) < plug_pct) ? REQ_PLUG : REQ_UNPLUG;
        r    = $urandom_range(0, 99);
        if (kind == REQ_UNPLUG && model_count > 0 && r < 60) begin
          port = model_ports[$urandom_range(0, model_count - 1)];
        end else if (r < 80) begin
          port = port_t'($urandom_range(0, 7));
        end else begin
          port = port_t'($urandom);
        end
        send_request(kind, port);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_PLUG;
    req_ch.port_id  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_fill_to_full();
    test_unplug_order();
    pause_until_drained();
    test_backpressure();
    test_random_traffic();
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
